[rtl/rbsi_pkg.sv]
// Shared types and constants for the ray/box slab intersection block.
// No dependencies; imported by every module of the block.
package rbsi_pkg;

    localparam int DATA_W    = 32;
    localparam int AXES      = 3;
    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = 4;
    localparam int REG_SEL_W = 3;
    localparam int REM_W     = 2 * DATA_W;
    localparam int DIV_LAT   = DATA_W + 3;

    localparam logic [CFG_IDX_W-1:0] REG_ORG_X = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORG_Y = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORG_Z = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_X = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Y = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Z = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_T_MIN = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_T_MAX = 4'd7;

    localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [AXES-1:0] dir_zero;
        logic            contain_fail;
    } slab_meta_t;

endpackage

[rtl/ray_box_slab_intersect.sv]
// Top level of the ray/box slab intersection pipeline with its ray registers.
// Depends on rbsi_pkg, rbsi_div and rbsi_narrow.
//
// Takes one box per clock while box_stall is low and returns one result per
// box, in order. A box passes the input register, then the slab dividers,
// which resolve one quotient bit per stage across six parallel pipelines,
// then the ordering and result registers. The whole pipeline holds while a
// result waits under res_stall, so box_stall follows res_stall whenever a
// result is pending. Ray registers are written through the cfg port, always
// ready, and must only change while no box is in flight.
module ray_box_slab_intersect
    import rbsi_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DATA_W-1:0]        cfg_data,
    input  logic                     box_valid,
    output logic                     box_stall,
    input  logic signed [DATA_W-1:0] box_min_x,
    input  logic signed [DATA_W-1:0] box_min_y,
    input  logic signed [DATA_W-1:0] box_min_z,
    input  logic signed [DATA_W-1:0] box_max_x,
    input  logic signed [DATA_W-1:0] box_max_y,
    input  logic signed [DATA_W-1:0] box_max_z,
    output logic                     res_valid,
    input  logic                     res_stall,
    output logic                     hit,
    output logic signed [DATA_W-1:0] t_enter,
    output logic signed [DATA_W-1:0] t_exit
);

    logic signed [DATA_W-1:0] cfg_reg [0:NUM_REGS-1];
    logic                     en;

    logic signed [DATA_W-1:0] lo [0:AXES-1];
    logic signed [DATA_W-1:0] hi [0:AXES-1];
    logic signed [DATA_W-1:0] org [0:AXES-1];
    logic signed [DATA_W-1:0] dir [0:AXES-1];

    logic                     s1_valid_reg;
    logic signed [DATA_W:0]   dlo_reg [0:AXES-1];
    logic signed [DATA_W:0]   dhi_reg [0:AXES-1];
    slab_meta_t               s1_meta_reg;
    slab_meta_t               s1_meta_next;

    logic                     dv_reg   [0:DIV_LAT-1];
    slab_meta_t               dmeta_reg [0:DIV_LAT-1];

    logic signed [DATA_W-1:0] qlo [0:AXES-1];
    logic signed [DATA_W-1:0] qhi [0:AXES-1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[REG_ORG_X[REG_SEL_W-1:0]] <= '0;
            cfg_reg[REG_ORG_Y[REG_SEL_W-1:0]] <= '0;
            cfg_reg[REG_ORG_Z[REG_SEL_W-1:0]] <= '0;
            cfg_reg[REG_DIR_X[REG_SEL_W-1:0]] <= 32'sd65536;
            cfg_reg[REG_DIR_Y[REG_SEL_W-1:0]] <= '0;
            cfg_reg[REG_DIR_Z[REG_SEL_W-1:0]] <= '0;
            cfg_reg[REG_T_MIN[REG_SEL_W-1:0]] <= '0;
            cfg_reg[REG_T_MAX[REG_SEL_W-1:0]] <= SAT_MAX;
        end
        else if (cfg_valid && cfg_ready && (cfg_index <= REG_T_MAX))
        begin
            cfg_reg[cfg_index[REG_SEL_W-1:0]] <= cfg_data;
        end
    end

    assign en        = !(res_valid && res_stall);
    assign box_stall = !en;

    assign lo[0] = box_min_x;
    assign lo[1] = box_min_y;
    assign lo[2] = box_min_z;
    assign hi[0] = box_max_x;
    assign hi[1] = box_max_y;
    assign hi[2] = box_max_z;
    assign org[0] = cfg_reg[REG_ORG_X[REG_SEL_W-1:0]];
    assign org[1] = cfg_reg[REG_ORG_Y[REG_SEL_W-1:0]];
    assign org[2] = cfg_reg[REG_ORG_Z[REG_SEL_W-1:0]];
    assign dir[0] = cfg_reg[REG_DIR_X[REG_SEL_W-1:0]];
    assign dir[1] = cfg_reg[REG_DIR_Y[REG_SEL_W-1:0]];
    assign dir[2] = cfg_reg[REG_DIR_Z[REG_SEL_W-1:0]];

    always_comb
    begin
        s1_meta_next = '0;
        for (int a = 0; a < AXES; a++)
        begin
            s1_meta_next.dir_zero[a] = (dir[a] == '0);
            if ((dir[a] == '0) && ((org[a] < lo[a]) || (org[a] > hi[a])))
                s1_meta_next.contain_fail = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            for (int s = 0; s < DIV_LAT; s++)
                dv_reg[s] <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= box_valid;
            dv_reg[0]    <= s1_valid_reg;
            for (int s = 1; s < DIV_LAT; s++)
                dv_reg[s] <= dv_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_meta_reg  <= s1_meta_next;
            dmeta_reg[0] <= s1_meta_reg;
            for (int s = 1; s < DIV_LAT; s++)
                dmeta_reg[s] <= dmeta_reg[s-1];
            for (int a = 0; a < AXES; a++)
            begin
                dlo_reg[a] <= (DATA_W+1)'(lo[a]) - (DATA_W+1)'(org[a]);
                dhi_reg[a] <= (DATA_W+1)'(hi[a]) - (DATA_W+1)'(org[a]);
            end
        end
    end

    for (genvar a = 0; a < AXES; a++)
    begin : g_axis
        rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_lo
        (
            .clk  (clk),
            .en   (en),
            .diff (dlo_reg[a]),
            .dir  (dir[a]),
            .quot (qlo[a])
        );

        rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_hi
        (
            .clk  (clk),
            .en   (en),
            .diff (dhi_reg[a]),
            .dir  (dir[a]),
            .quot (qhi[a])
        );
    end

    rbsi_narrow u_narrow
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (dv_reg[DIV_LAT-1]),
        .meta      (dmeta_reg[DIV_LAT-1]),
        .t_lo      (qlo),
        .t_hi      (qhi),
        .t_min     (cfg_reg[REG_T_MIN[REG_SEL_W-1:0]]),
        .t_max     (cfg_reg[REG_T_MAX[REG_SEL_W-1:0]]),
        .out_valid (res_valid),
        .out_hit   (hit),
        .out_enter (t_enter),
        .out_exit  (t_exit)
    );

endmodule

[rtl/rbsi_div.sv]
// Pipelined signed divider, one quotient bit per stage, truncating and saturating.
// Depends on rbsi_pkg.
module rbsi_div
    import rbsi_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [DATA_W:0]   diff,
    input  logic signed [DATA_W-1:0] dir,
    output logic signed [DATA_W-1:0] quot
);

    localparam int NUM_W = DATA_W + 1 + FRAC_BITS;

    logic [NUM_W-1:0]   nmag_reg;
    logic [DATA_W-1:0]  dmag0_reg;
    logic               neg0_reg;
    logic [DATA_W:0]    diff_mag;
    logic [DATA_W-1:0]  dir_mag;

    logic [REM_W-1:0]   rem_reg  [0:DATA_W];
    logic [DATA_W-1:0]  q_reg    [0:DATA_W];
    logic [DATA_W-1:0]  dmag_reg [0:DATA_W];
    logic               neg_reg  [0:DATA_W];
    logic               ovf_reg  [0:DATA_W];

    logic signed [DATA_W-1:0] quot_reg;
    logic signed [DATA_W-1:0] quot_next;
    logic [DATA_W-1:0]        q_last;

    assign diff_mag = diff[DATA_W] ? (DATA_W+1)'(-diff) : (DATA_W+1)'(diff);
    assign dir_mag  = dir[DATA_W-1] ? DATA_W'(-dir) : DATA_W'(dir);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nmag_reg  <= {diff_mag, {FRAC_BITS{1'b0}}};
            dmag0_reg <= dir_mag;
            neg0_reg  <= diff[DATA_W] ^ dir[DATA_W-1];
            rem_reg[0]  <= REM_W'(nmag_reg);
            q_reg[0]    <= '0;
            dmag_reg[0] <= dmag0_reg;
            neg_reg[0]  <= neg0_reg;
            ovf_reg[0]  <= REM_W'(nmag_reg) >= {dmag0_reg, {DATA_W{1'b0}}};
        end
    end

    for (genvar k = 0; k < DATA_W; k++)
    begin : g_stage
        localparam int BIT = DATA_W - 1 - k;
        logic [REM_W-1:0] sub;
        logic             take;

        assign sub  = REM_W'(dmag_reg[k]) << BIT;
        assign take = rem_reg[k] >= sub;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= take ? rem_reg[k] - sub : rem_reg[k];
                q_reg[k+1]    <= q_reg[k] | (take ? (DATA_W'(1) << BIT) : '0);
                dmag_reg[k+1] <= dmag_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
                ovf_reg[k+1]  <= ovf_reg[k];
            end
        end
    end

    assign q_last = q_reg[DATA_W];

    always_comb
    begin
        if (neg_reg[DATA_W])
        begin
            if (ovf_reg[DATA_W] || (q_last > (DATA_W'(1) << (DATA_W - 1))))
                quot_next = SAT_MIN;
            else
                quot_next = DATA_W'(-q_last);
        end
        else
        begin
            if (ovf_reg[DATA_W] || q_last[DATA_W-1])
                quot_next = SAT_MAX;
            else
                quot_next = q_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            quot_reg <= quot_next;
    end

    assign quot = quot_reg;

endmodule

[rtl/rbsi_narrow.sv]
// Orders slab distances per axis and narrows the ray interval into the result register.
// Depends on rbsi_pkg.
module rbsi_narrow
    import rbsi_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  slab_meta_t               meta,
    input  logic signed [DATA_W-1:0] t_lo [0:AXES-1],
    input  logic signed [DATA_W-1:0] t_hi [0:AXES-1],
    input  logic signed [DATA_W-1:0] t_min,
    input  logic signed [DATA_W-1:0] t_max,
    output logic                     out_valid,
    output logic                     out_hit,
    output logic signed [DATA_W-1:0] out_enter,
    output logic signed [DATA_W-1:0] out_exit
);

    logic                     ord_valid_reg;
    slab_meta_t               ord_meta_reg;
    logic signed [DATA_W-1:0] tn_reg [0:AXES-1];
    logic signed [DATA_W-1:0] tf_reg [0:AXES-1];

    logic                     res_valid_reg;
    logic                     hit_reg;
    logic signed [DATA_W-1:0] enter_reg;
    logic signed [DATA_W-1:0] exit_reg;

    logic signed [DATA_W-1:0] t0_next;
    logic signed [DATA_W-1:0] t1_next;
    logic                     hit_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ord_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            ord_valid_reg <= in_valid;
            res_valid_reg <= ord_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ord_meta_reg <= meta;
            for (int a = 0; a < AXES; a++)
            begin
                tn_reg[a] <= (t_lo[a] > t_hi[a]) ? t_hi[a] : t_lo[a];
                tf_reg[a] <= (t_lo[a] > t_hi[a]) ? t_lo[a] : t_hi[a];
            end
        end
    end

    always_comb
    begin
        t0_next = t_min;
        t1_next = t_max;
        for (int a = 0; a < AXES; a++)
        begin
            if (!ord_meta_reg.dir_zero[a])
            begin
                if (tn_reg[a] > t0_next)
                    t0_next = tn_reg[a];
                if (tf_reg[a] < t1_next)
                    t1_next = tf_reg[a];
            end
        end
        hit_next = !ord_meta_reg.contain_fail && !(t0_next > t1_next);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg   <= hit_next;
            enter_reg <= hit_next ? t0_next : '0;
            exit_reg  <= hit_next ? t1_next : '0;
        end
    end

    assign out_valid = res_valid_reg;
    assign out_hit   = hit_reg;
    assign out_enter = enter_reg;
    assign out_exit  = exit_reg;

endmodule

[rtl/rbsi_checker.sv]
// Port-level checks for ray_box_slab_intersect, bound to the top level.
// Depends on rbsi_pkg.
module rbsi_checker
    import rbsi_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     box_stall,
    input logic                     res_valid,
    input logic                     res_stall,
    input logic                     hit,
    input logic signed [DATA_W-1:0] t_enter,
    input logic signed [DATA_W-1:0] t_exit
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result request dropped under stall");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> $stable(hit) && $stable(t_enter) && $stable(t_exit))
        else $error("stalled result request changed");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !hit |-> (t_enter == '0) && (t_exit == '0))
        else $error("miss with nonzero interval");

    a_hit_order: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && hit |-> !(t_enter > t_exit))
        else $error("hit with empty interval");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        box_stall == (res_valid && res_stall))
        else $error("box stall does not follow pending result");

endmodule

bind ray_box_slab_intersect rbsi_checker u_rbsi_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .box_stall (box_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .hit       (hit),
    .t_enter   (t_enter),
    .t_exit    (t_exit)
);
